[hw/rtl/bole_pkg.sv]
// ----------------------------------------------------------------------------
// bole_pkg
// Shared types, widths and codes for the bounded ordered list engine.
// ----------------------------------------------------------------------------
package bole_pkg;

  // List storage depth; the list holds at most DEPTH-1 items
  localparam int DEPTH = 64;
  localparam int CNT_W = $clog2(DEPTH);
  localparam int POS_W = 6;
  localparam int WORD_W = 32;
  // Compare width: wide enough for positions, counts and one carry bit
  localparam int EXT_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [EXT_W-1:0] ext_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic signed [WORD_W-1:0] word_t;

  // Command codes
  typedef enum logic [3:0] {
    CMD_CLEAR     = 4'd0,
    CMD_INS_FRONT = 4'd1,
    CMD_INS_BACK  = 4'd2,
    CMD_INS_AT    = 4'd3,
    CMD_RM_FRONT  = 4'd4,
    CMD_RM_BACK   = 4'd5,
    CMD_RM_AT     = 4'd6,
    CMD_GET       = 4'd7,
    CMD_SEEK      = 4'd8,
    CMD_SWAP      = 4'd9
  } cmd_t;

  // Memory address source
  typedef enum logic [2:0] {
    ADDR_IDX    = 3'd0,
    ADDR_IDX_M1 = 3'd1,
    ADDR_IDX_P1 = 3'd2,
    ADDR_AT     = 3'd3,
    ADDR_PA     = 3'd4,
    ADDR_PB     = 3'd5
  } addr_sel_t;

  // Memory write data source
  typedef enum logic [1:0] {
    WD_RD  = 2'd0,
    WD_VAL = 2'd1,
    WD_TMP = 2'd2
  } wdata_sel_t;

  // Walk index update
  typedef enum logic [2:0] {
    IDX_HOLD = 3'd0,
    IDX_CNT  = 3'd1,
    IDX_AT   = 3'd2,
    IDX_ZERO = 3'd3,
    IDX_INC  = 3'd4,
    IDX_DEC  = 3'd5
  } idx_op_t;

  // Item count update
  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_CLR  = 2'd1,
    CNT_INC  = 2'd2,
    CNT_DEC  = 2'd3
  } cnt_op_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       latch;
    logic       mem_rd;
    logic       mem_wr;
    addr_sel_t  addr_sel;
    wdata_sel_t wdata_sel;
    idx_op_t    idx_op;
    cnt_op_t    cnt_op;
    logic       set_ok;
    logic       set_rd_hit;
    logic       set_rd_miss;
    logic       set_found;
    logic       tmp_ld;
    logic       out_ld;
  } bole_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic [3:0] cmd;
    logic       full;
    logic       empty;
    logic       pa_ok;
    logic       pb_ok;
    logic       ins_first;
    logic       ins_more;
    logic       rm_first;
    logic       rm_more;
    logic       sk_more;
    logic       match;
    logic       out_free;
  } bole_sts_t;

endpackage

[hw/rtl/bole_ctrl.sv]
// ----------------------------------------------------------------------------
// bole_ctrl
// Command sequencer: steps each command through its memory accesses.
// ----------------------------------------------------------------------------
module bole_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bole_pkg::bole_sts_t sts,
  output bole_pkg::bole_ctl_t ctl
);

  typedef enum logic [16:0] {
    ST_IDLE     = 17'h00001,
    ST_SETUP    = 17'h00002,
    ST_INS_RD   = 17'h00004,
    ST_INS_WR   = 17'h00008,
    ST_INS_PUT  = 17'h00010,
    ST_RM_RD    = 17'h00020,
    ST_RM_WR    = 17'h00040,
    ST_RM_END   = 17'h00080,
    ST_GET_RD   = 17'h00100,
    ST_GET_DATA = 17'h00200,
    ST_SK_RD    = 17'h00400,
    ST_SK_CMP   = 17'h00800,
    ST_SW_RDA   = 17'h01000,
    ST_SW_RDB   = 17'h02000,
    ST_SW_WRA   = 17'h04000,
    ST_SW_WRB   = 17'h08000,
    ST_DONE     = 17'h10000
  } state_t;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    ctl           = '0;
    ctl.addr_sel  = bole_pkg::ADDR_IDX;
    ctl.wdata_sel = bole_pkg::WD_RD;
    ctl.idx_op    = bole_pkg::IDX_HOLD;
    ctl.cnt_op    = bole_pkg::CNT_HOLD;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.latch = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_nxt = ST_DONE;
        case (sts.cmd)
          bole_pkg::CMD_CLEAR: begin
            ctl.cnt_op = bole_pkg::CNT_CLR;
            ctl.set_ok = 1'b1;
          end
          bole_pkg::CMD_INS_FRONT, bole_pkg::CMD_INS_BACK, bole_pkg::CMD_INS_AT: begin
            if (!sts.full && (sts.cmd != bole_pkg::CMD_INS_AT || sts.pa_ok)) begin
              ctl.idx_op = bole_pkg::IDX_CNT;
              state_nxt  = sts.ins_first ? ST_INS_RD : ST_INS_PUT;
            end
          end
          bole_pkg::CMD_RM_FRONT, bole_pkg::CMD_RM_BACK, bole_pkg::CMD_RM_AT: begin
            if ((sts.cmd == bole_pkg::CMD_RM_AT) ? sts.pa_ok : !sts.empty) begin
              ctl.idx_op = bole_pkg::IDX_AT;
              state_nxt  = sts.rm_first ? ST_RM_RD : ST_RM_END;
            end
          end
          bole_pkg::CMD_GET: begin
            if (sts.pa_ok) begin
              state_nxt = ST_GET_RD;
            end else begin
              ctl.set_rd_miss = 1'b1;
            end
          end
          bole_pkg::CMD_SEEK: begin
            ctl.idx_op = bole_pkg::IDX_ZERO;
            if (!sts.empty) begin
              state_nxt = ST_SK_RD;
            end
          end
          bole_pkg::CMD_SWAP: begin
            if (sts.pa_ok && sts.pb_ok) begin
              state_nxt = ST_SW_RDA;
            end
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      // Insert: move items up from the tail, then drop the new value in
      ST_INS_RD: begin
        ctl.mem_rd   = 1'b1;
        ctl.addr_sel = bole_pkg::ADDR_IDX_M1;
        state_nxt    = ST_INS_WR;
      end
      ST_INS_WR: begin
        ctl.mem_wr    = 1'b1;
        ctl.addr_sel  = bole_pkg::ADDR_IDX;
        ctl.wdata_sel = bole_pkg::WD_RD;
        ctl.idx_op    = bole_pkg::IDX_DEC;
        state_nxt     = sts.ins_more ? ST_INS_RD : ST_INS_PUT;
      end
      ST_INS_PUT: begin
        ctl.mem_wr    = 1'b1;
        ctl.addr_sel  = bole_pkg::ADDR_AT;
        ctl.wdata_sel = bole_pkg::WD_VAL;
        ctl.cnt_op    = bole_pkg::CNT_INC;
        ctl.set_ok    = 1'b1;
        state_nxt     = ST_DONE;
      end
      // Remove: move items down toward the removed slot
      ST_RM_RD: begin
        ctl.mem_rd   = 1'b1;
        ctl.addr_sel = bole_pkg::ADDR_IDX_P1;
        state_nxt    = ST_RM_WR;
      end
      ST_RM_WR: begin
        ctl.mem_wr    = 1'b1;
        ctl.addr_sel  = bole_pkg::ADDR_IDX;
        ctl.wdata_sel = bole_pkg::WD_RD;
        ctl.idx_op    = bole_pkg::IDX_INC;
        state_nxt     = sts.rm_more ? ST_RM_RD : ST_RM_END;
      end
      ST_RM_END: begin
        ctl.cnt_op = bole_pkg::CNT_DEC;
        ctl.set_ok = 1'b1;
        state_nxt  = ST_DONE;
      end
      // Get
      ST_GET_RD: begin
        ctl.mem_rd   = 1'b1;
        ctl.addr_sel = bole_pkg::ADDR_PA;
        state_nxt    = ST_GET_DATA;
      end
      ST_GET_DATA: begin
        ctl.set_rd_hit = 1'b1;
        ctl.set_ok     = 1'b1;
        state_nxt      = ST_DONE;
      end
      // Seek: linear scan over the live items
      ST_SK_RD: begin
        ctl.mem_rd   = 1'b1;
        ctl.addr_sel = bole_pkg::ADDR_IDX;
        state_nxt    = ST_SK_CMP;
      end
      ST_SK_CMP: begin
        if (sts.match) begin
          ctl.set_found = 1'b1;
          ctl.set_ok    = 1'b1;
          state_nxt     = ST_DONE;
        end else begin
          ctl.idx_op = bole_pkg::IDX_INC;
          state_nxt  = sts.sk_more ? ST_SK_RD : ST_DONE;
        end
      end
      // Swap: read both, write both
      ST_SW_RDA: begin
        ctl.mem_rd   = 1'b1;
        ctl.addr_sel = bole_pkg::ADDR_PA;
        state_nxt    = ST_SW_RDB;
      end
      ST_SW_RDB: begin
        ctl.mem_rd   = 1'b1;
        ctl.addr_sel = bole_pkg::ADDR_PB;
        ctl.tmp_ld   = 1'b1;
        state_nxt    = ST_SW_WRA;
      end
      ST_SW_WRA: begin
        ctl.mem_wr    = 1'b1;
        ctl.addr_sel  = bole_pkg::ADDR_PA;
        ctl.wdata_sel = bole_pkg::WD_RD;
        state_nxt     = ST_SW_WRB;
      end
      ST_SW_WRB: begin
        ctl.mem_wr    = 1'b1;
        ctl.addr_sel  = bole_pkg::ADDR_PB;
        ctl.wdata_sel = bole_pkg::WD_TMP;
        ctl.set_ok    = 1'b1;
        state_nxt     = ST_DONE;
      end
      // Hand the result to the output register once it is free
      ST_DONE: begin
        if (sts.out_free) begin
          ctl.out_ld = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/bole_dp.sv]
// ----------------------------------------------------------------------------
// bole_dp
// Datapath: item memory, count, walk index, result and output registers.
// ----------------------------------------------------------------------------
module bole_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  bole_pkg::bole_ctl_t ctl,
  output bole_pkg::bole_sts_t sts,
  input  logic [3:0]          in_cmd,
  input  logic [5:0]          in_position_a,
  input  logic [5:0]          in_position_b,
  input  logic signed [31:0]  in_item_value,
  input  logic                cfg_valid,
  input  logic signed [31:0]  cfg_data,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_ok,
  output logic signed [31:0]  out_read_value,
  output logic [5:0]          out_found_position,
  output logic [5:0]          out_list_size,
  output logic                out_is_empty
);

  // Item memory, single port
  bole_pkg::word_t mem_r [bole_pkg::DEPTH];
  bole_pkg::word_t rd_r;

  // Latched command beat
  logic [3:0]      cmd_r;
  bole_pkg::pos_t  pa_r;
  bole_pkg::pos_t  pb_r;
  bole_pkg::word_t val_r;

  bole_pkg::cnt_t  cnt_r, cnt_nxt;
  bole_pkg::cnt_t  idx_r, idx_nxt;
  bole_pkg::word_t tmp_r;
  bole_pkg::word_t miss_r;

  // Result being built
  logic            res_ok_r;
  bole_pkg::word_t res_rd_r;
  bole_pkg::pos_t  res_found_r;

  // Output register
  logic            out_valid_r;
  logic            out_ok_r;
  bole_pkg::word_t out_rd_r;
  bole_pkg::pos_t  out_found_r;
  bole_pkg::pos_t  out_size_r;
  logic            out_empty_r;

  bole_pkg::ext_t  cnt_x, idx_x, pa_x, pb_x, at_x;
  bole_pkg::cnt_t  pa_idx, pb_idx, at_c, addr;
  bole_pkg::word_t wdata;

  // Widened operands for compares
  assign cnt_x  = bole_pkg::ext_t'(cnt_r);
  assign idx_x  = bole_pkg::ext_t'(idx_r);
  assign pa_x   = bole_pkg::ext_t'(pa_r);
  assign pb_x   = bole_pkg::ext_t'(pb_r);
  assign pa_idx = bole_pkg::cnt_t'(pa_x - bole_pkg::ext_t'(1));
  assign pb_idx = bole_pkg::cnt_t'(pb_x - bole_pkg::ext_t'(1));

  // Zero-based slot the command works on
  always_comb begin
    case (cmd_r)
      bole_pkg::CMD_INS_BACK: at_c = cnt_r;
      bole_pkg::CMD_RM_BACK:  at_c = cnt_r - bole_pkg::cnt_t'(1);
      bole_pkg::CMD_INS_AT, bole_pkg::CMD_RM_AT: at_c = pa_idx;
      default:                at_c = '0;
    endcase
  end
  assign at_x = bole_pkg::ext_t'(at_c);

  // Status to the controller
  assign sts.cmd       = cmd_r;
  assign sts.full      = (cnt_x == bole_pkg::ext_t'(bole_pkg::DEPTH - 1));
  assign sts.empty     = (cnt_r == '0);
  assign sts.pa_ok     = (pa_r != '0) && (pa_x <= cnt_x);
  assign sts.pb_ok     = (pb_r != '0) && (pb_x <= cnt_x);
  assign sts.ins_first = (cnt_x > at_x);
  assign sts.ins_more  = (idx_x > at_x + bole_pkg::ext_t'(1));
  assign sts.rm_first  = (at_x + bole_pkg::ext_t'(1) < cnt_x);
  assign sts.rm_more   = (idx_x + bole_pkg::ext_t'(2) < cnt_x);
  assign sts.sk_more   = (idx_x + bole_pkg::ext_t'(1) < cnt_x);
  assign sts.match     = (rd_r == val_r);
  assign sts.out_free  = !out_valid_r || !out_stall;

  // Address and write data select
  always_comb begin
    case (ctl.addr_sel)
      bole_pkg::ADDR_IDX:    addr = idx_r;
      bole_pkg::ADDR_IDX_M1: addr = idx_r - bole_pkg::cnt_t'(1);
      bole_pkg::ADDR_IDX_P1: addr = idx_r + bole_pkg::cnt_t'(1);
      bole_pkg::ADDR_AT:     addr = at_c;
      bole_pkg::ADDR_PA:     addr = pa_idx;
      bole_pkg::ADDR_PB:     addr = pb_idx;
      default:               addr = idx_r;
    endcase
    case (ctl.wdata_sel)
      bole_pkg::WD_RD:  wdata = rd_r;
      bole_pkg::WD_VAL: wdata = val_r;
      bole_pkg::WD_TMP: wdata = tmp_r;
      default:          wdata = rd_r;
    endcase
  end

  // Memory port, registered read
  always_ff @(posedge clk) begin
    if (ctl.mem_wr) begin
      mem_r[addr] <= wdata;
    end
    if (ctl.mem_rd) begin
      rd_r <= mem_r[addr];
    end
  end

  // Index and count next values
  always_comb begin
    case (ctl.idx_op)
      bole_pkg::IDX_CNT:  idx_nxt = cnt_r;
      bole_pkg::IDX_AT:   idx_nxt = at_c;
      bole_pkg::IDX_ZERO: idx_nxt = '0;
      bole_pkg::IDX_INC:  idx_nxt = idx_r + bole_pkg::cnt_t'(1);
      bole_pkg::IDX_DEC:  idx_nxt = idx_r - bole_pkg::cnt_t'(1);
      default:            idx_nxt = idx_r;
    endcase
    case (ctl.cnt_op)
      bole_pkg::CNT_CLR: cnt_nxt = '0;
      bole_pkg::CNT_INC: cnt_nxt = cnt_r + bole_pkg::cnt_t'(1);
      bole_pkg::CNT_DEC: cnt_nxt = cnt_r - bole_pkg::cnt_t'(1);
      default:           cnt_nxt = cnt_r;
    endcase
  end

  // Control state: count, miss value, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      miss_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cfg_valid) begin
        miss_r <= cfg_data;
      end
      if (ctl.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (ctl.latch) begin
      cmd_r       <= in_cmd;
      pa_r        <= in_position_a;
      pb_r        <= in_position_b;
      val_r       <= in_item_value;
      res_ok_r    <= 1'b0;
      res_rd_r    <= '0;
      res_found_r <= '0;
    end else begin
      if (ctl.set_ok) begin
        res_ok_r <= 1'b1;
      end
      if (ctl.set_rd_hit) begin
        res_rd_r <= rd_r;
      end else if (ctl.set_rd_miss) begin
        res_rd_r <= miss_r;
      end
      if (ctl.set_found) begin
        res_found_r <= bole_pkg::pos_t'(idx_x + bole_pkg::ext_t'(1));
      end
    end
    if (ctl.tmp_ld) begin
      tmp_r <= rd_r;
    end
    if (ctl.out_ld) begin
      out_ok_r    <= res_ok_r;
      out_rd_r    <= res_rd_r;
      out_found_r <= res_found_r;
      out_size_r  <= bole_pkg::pos_t'(cnt_r);
      out_empty_r <= (cnt_r == '0);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_ok             = out_ok_r;
  assign out_read_value     = out_rd_r;
  assign out_found_position = out_found_r;
  assign out_list_size      = out_size_r;
  assign out_is_empty       = out_empty_r;

endmodule

[hw/rtl/bounded_ordered_list_engine_unit.sv]
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine_unit
// Ordered list of signed words with insert, remove, get, seek and swap.
// ----------------------------------------------------------------------------
// Commands are taken one at a time; in_stall stays high until the result is loaded
//   into the output register. Each shifted item costs a read and a write of the
//   single-port item memory, and each scanned item a read and a compare.
// Reset (synchronous, rst_n low): controller idle, count and miss value zero,
//   output empty; item memory contents are not initialized.
module bounded_ordered_list_engine_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_cmd,
  input  logic [5:0]         in_position_a,
  input  logic [5:0]         in_position_b,
  input  logic signed [31:0] in_item_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_ok,
  output logic signed [31:0] out_read_value,
  output logic [5:0]         out_found_position,
  output logic [5:0]         out_list_size,
  output logic               out_is_empty,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [31:0] cfg_data
);

  bole_pkg::bole_ctl_t ctl;
  bole_pkg::bole_sts_t sts;

  // Register write is always taken
  assign cfg_ready = 1'b1;

  bole_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  bole_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .sts                (sts),
    .in_cmd             (in_cmd),
    .in_position_a      (in_position_a),
    .in_position_b      (in_position_b),
    .in_item_value      (in_item_value),
    .cfg_valid          (cfg_valid),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_ok             (out_ok),
    .out_read_value     (out_read_value),
    .out_found_position (out_found_position),
    .out_list_size      (out_list_size),
    .out_is_empty       (out_is_empty)
  );

endmodule
